FILE: src/cba_pkg.sv
package cba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int BLK_W      = 10;
  localparam int CNT_W      = 11;
  localparam int CMD_W      = 2;
  localparam int WORD_W     = 8;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WORDS      = MAX_BLOCKS / WORD_W;
  localparam int WADDR_W    = $clog2(WORDS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [BLK_W-1:0] DS_RST  = BLK_W'(1);
  localparam logic [CNT_W-1:0] BT_RST  = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(1024 - 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_START  = 1'b0,
    CFG_BLOCK_TOTAL = 1'b1
  } cfg_idx_t;

endpackage

FILE: src/cba_if.sv
interface cba_req_if;
  logic                        valid;
  logic                        ready;
  logic [cba_pkg::CMD_W-1:0]   cmd;
  logic [cba_pkg::CNT_W-1:0]   block_count;
  logic [cba_pkg::BLK_W-1:0]   range_start;
  modport source (output valid, cmd, block_count, range_start, input ready);
  modport sink   (input valid, cmd, block_count, range_start, output ready);
endinterface

interface cba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [cba_pkg::BLK_W-1:0]   alloc_start;
  logic [cba_pkg::CNT_W-1:0]   free_left;
  modport source (output valid, status, alloc_start, free_left, input ready);
  modport sink   (input valid, status, alloc_start, free_left, output ready);
endinterface

FILE: src/contiguous_block_allocator.sv
// Contiguous block allocator, first fit over a used-bit map in one RAM of 8-bit words.
// Allocate reads and scans map words from data_start, then rewrites each word of the run;
// free rewrites each touched word; clear and rejected requests go straight to the result.
// Throughput: one request at a time, set by the word-by-word walk over the map RAM.
// Reset: synchronous active-low rst_n; map reads as all free via per-word valid bits,
// counter 1023, data_start 1, block_total 1024.
module contiguous_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  cba_req_if.sink                        in_req,
  cba_rsp_if.source                      out_rsp,
  input  logic                           cfg_we,
  input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_MARK_RD, ST_MARK_WR, ST_DONE
  } state_t;

  state_t             state_r;
  logic [BLK_W-1:0]   ds_r;
  logic [CNT_W-1:0]   bt_r;
  logic [CNT_W-1:0]   counter_r;
  logic [CNT_W-1:0]   need_r;
  logic [CNT_W-1:0]   run_r;
  logic [BLK_W-1:0]   first_r;
  logic [BLK_W-1:0]   lo_r;
  logic [BLK_W-1:0]   hi_r;
  logic [WADDR_W-1:0] cur_w_r;
  logic [WADDR_W-1:0] last_w_r;
  logic               op_set_r;
  logic               res_status_r;
  logic [BLK_W-1:0]   res_start_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [BLK_W-1:0]   out_start_r;
  logic [CNT_W-1:0]   out_left_r;

  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   reload;
  logic               accept;
  logic [CNT_W:0]     fr_end;
  logic [CNT_W:0]     fr_lim;
  logic [CNT_W-1:0]   fr_cnt;
  logic [CNT_W:0]     fr_sum;
  logic [CNT_W-1:0]   fr_new;
  logic [CNT_W-1:0]   tot_m1;

  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_clr;
  logic [WORD_W-1:0]  mark_m;

  logic [CNT_W-1:0]   run_out;
  logic [BLK_W-1:0]   first_out;
  logic               found;

  // Clamp the device size and derive the clear reload value
  assign total  = (bt_r > MAX_CNT) ? MAX_CNT : bt_r;
  assign reload = ({1'b0, ds_r} > total) ? '0 : total - {1'b0, ds_r};
  assign tot_m1 = total - CNT_W'(1);
  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  // Count the blocks of a free range that lie below the total, then saturate
  assign fr_end = {2'b0, in_req.range_start} + {1'b0, in_req.block_count};
  assign fr_lim = (fr_end > {1'b0, total}) ? {1'b0, total} : fr_end;
  assign fr_cnt = (fr_lim > {2'b0, in_req.range_start})
                  ? CNT_W'(fr_lim - {2'b0, in_req.range_start}) : '0;
  assign fr_sum = {1'b0, counter_r} + {1'b0, fr_cnt};
  assign fr_new = (fr_sum > {1'b0, MAX_CNT}) ? MAX_CNT : fr_sum[CNT_W-1:0];

  // Mark mask for the word under modification
  always_comb begin
    logic [BLK_W-1:0] idx;
    for (int k = 0; k < WORD_W; k++) begin
      idx       = {cur_w_r, BIT_W'(k)};
      mark_m[k] = (idx >= lo_r) && (idx <= hi_r);
    end
  end

  // Drive the map RAM ports
  always_comb begin
    ram_raddr = cur_w_r;
    if (state_r == ST_SCAN) begin
      ram_raddr = cur_w_r + WADDR_W'(1);
    end
    ram_we    = (state_r == ST_MARK_WR);
    ram_wdata = op_set_r ? (ram_rdata | mark_m) : (ram_rdata & ~mark_m);
    ram_clr   = accept && (in_req.cmd == CMD_CLEAR);
  end

  cba_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ram_clr),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (cur_w_r),
    .wdata (ram_wdata)
  );

  cba_scan u_scan (
    .word      (ram_rdata),
    .widx      (cur_w_r),
    .ds        (ds_r),
    .total     (total),
    .need      (need_r),
    .run_in    (run_r),
    .first_in  (first_r),
    .run_out   (run_out),
    .first_out (first_out),
    .found     (found)
  );

  // Sequence requests, hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ds_r        <= DS_RST;
      bt_r        <= BT_RST;
      counter_r   <= CNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DATA_START:  ds_r <= cfg_wdata[BLK_W-1:0];
          CFG_BLOCK_TOTAL: bt_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // Drop the result after its transfer unless a new one is loaded
      if (out_rsp.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            res_status_r <= 1'b1;
            res_start_r  <= '0;
            state_r      <= ST_DONE;
            case (in_req.cmd)
              CMD_ALLOC: begin
                need_r   <= in_req.block_count;
                run_r    <= '0;
                first_r  <= '0;
                cur_w_r  <= ds_r[BLK_W-1:BIT_W];
                last_w_r <= tot_m1[BLK_W-1:BIT_W];
                if (in_req.block_count != '0 && in_req.block_count <= counter_r &&
                    {1'b0, ds_r} < total) begin
                  state_r <= ST_SCAN_RD;
                end
              end
              CMD_FREE: begin
                res_status_r <= 1'b0;
                counter_r    <= fr_new;
                lo_r         <= in_req.range_start;
                hi_r         <= BLK_W'(fr_lim - 1'b1);
                cur_w_r      <= in_req.range_start[BLK_W-1:BIT_W];
                op_set_r     <= 1'b0;
                if (fr_cnt != '0) begin
                  state_r <= ST_MARK_RD;
                end
              end
              CMD_CLEAR: begin
                res_status_r <= 1'b0;
                counter_r    <= reload;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN_RD: begin
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (found) begin
            counter_r    <= counter_r - need_r;
            lo_r         <= first_out;
            hi_r         <= BLK_W'({1'b0, first_out} + need_r - CNT_W'(1));
            cur_w_r      <= first_out[BLK_W-1:BIT_W];
            op_set_r     <= 1'b1;
            res_status_r <= 1'b0;
            res_start_r  <= first_out;
            state_r      <= ST_MARK_RD;
          end else if (cur_w_r == last_w_r) begin
            state_r <= ST_DONE;
          end else begin
            cur_w_r <= cur_w_r + WADDR_W'(1);
            run_r   <= run_out;
            first_r <= first_out;
          end
        end
        ST_MARK_RD: begin
          state_r <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          if (cur_w_r == hi_r[BLK_W-1:BIT_W]) begin
            state_r <= ST_DONE;
          end else begin
            cur_w_r <= cur_w_r + WADDR_W'(1);
            state_r <= ST_MARK_RD;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_start_r  <= res_start_r;
            out_left_r   <= counter_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.alloc_start = out_start_r;
  assign out_rsp.free_left   = out_left_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    counter_r <= MAX_CNT) else $error("free counter above maximum");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !ram_we) else $error("map write while idle");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cur_w_r <= last_w_r)) else $error("scan past last word");
  a_mark_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK_WR) |-> $past(state_r == ST_MARK_RD))
    else $error("map write without read");
`endif

endmodule

FILE: src/cba_ram.sv
module cba_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic [cba_pkg::WADDR_W-1:0] raddr,
  output logic [cba_pkg::WORD_W-1:0]  rdata,
  input  logic                        we,
  input  logic [cba_pkg::WADDR_W-1:0] waddr,
  input  logic [cba_pkg::WORD_W-1:0]  wdata
);
  import cba_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  valid_r;
  logic [WORD_W-1:0] rdata_r;
  logic              rvld_r;

  // Store data and register the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Track written words; a clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      rvld_r <= valid_r[raddr];
      if (clr) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

FILE: src/cba_scan.sv
module cba_scan (
  input  logic [cba_pkg::WORD_W-1:0]  word,
  input  logic [cba_pkg::WADDR_W-1:0] widx,
  input  logic [cba_pkg::BLK_W-1:0]   ds,
  input  logic [cba_pkg::CNT_W-1:0]   total,
  input  logic [cba_pkg::CNT_W-1:0]   need,
  input  logic [cba_pkg::CNT_W-1:0]   run_in,
  input  logic [cba_pkg::BLK_W-1:0]   first_in,
  output logic [cba_pkg::CNT_W-1:0]   run_out,
  output logic [cba_pkg::BLK_W-1:0]   first_out,
  output logic                        found
);
  import cba_pkg::*;

  // Walk the bits of one word, extending the current free run
  always_comb begin
    logic [BLK_W-1:0] idx;
    logic             usable;
    run_out   = run_in;
    first_out = first_in;
    found     = 1'b0;
    for (int k = 0; k < WORD_W; k++) begin
      idx    = {widx, BIT_W'(k)};
      usable = !word[k] && (idx >= ds) && ({1'b0, idx} < total);
      if (!found) begin
        if (usable) begin
          if (run_out == '0) begin
            first_out = idx;
          end
          run_out = run_out + CNT_W'(1);
          if (run_out == need) begin
            found = 1'b1;
          end
        end else begin
          run_out = '0;
        end
      end
    end
  end

endmodule

FILE: bench/testbench.sv
module testbench;
  import cba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cba_req_if req_ch();
  cba_rsp_if rsp_ch();

  contiguous_block_allocator uut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] alloc_start;
    logic [CNT_W-1:0] free_left;
  } alloc_reply_t;

  // Shadow state of the allocator
  bit               shadow_map [MAX_BLOCKS];
  int unsigned      shadow_free;
  int unsigned      shadow_ds;
  int unsigned      shadow_total;
  alloc_reply_t     pending_replies [$];
  int               err_cnt = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned clamp_total();
    return (shadow_total > MAX_BLOCKS) ? MAX_BLOCKS : shadow_total;
  endfunction

  function automatic int unsigned reload_count();
    int unsigned t;
    t = clamp_total();
    return (shadow_ds > t) ? 0 : t - shadow_ds;
  endfunction

  function automatic alloc_reply_t apply_request(logic [CMD_W-1:0] op, int unsigned n,
                                                 int unsigned rs);
    alloc_reply_t r;
    int unsigned total, run, first;
    total = clamp_total();
    r.status = 1'b1;
    r.alloc_start = '0;
    case (op)
      CMD_ALLOC: begin
        if (n != 0 && n <= shadow_free) begin
          run = 0;
          first = 0;
          for (int unsigned i = shadow_ds; i < total; i++) begin
            if (!shadow_map[i]) begin
              if (run == 0) first = i;
              run++;
              if (run == n) begin
                for (int unsigned j = first; j < first + n; j++) shadow_map[j] = 1'b1;
                shadow_free -= n;
                r.status = 1'b0;
                r.alloc_start = first[BLK_W-1:0];
                break;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      CMD_FREE: begin
        for (int unsigned i = rs; i < rs + n; i++) begin
          if (i < total) begin
            shadow_map[i] = 1'b0;
            if (shadow_free < MAX_BLOCKS) shadow_free++;
          end
        end
        r.status = 1'b0;
      end
      CMD_CLEAR: begin
        foreach (shadow_map[i]) shadow_map[i] = 1'b0;
        shadow_free = reload_count();
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.free_left = shadow_free[CNT_W-1:0];
    return r;
  endfunction

  // Drive one request and hold it until the transfer
  task automatic send_request(logic [CMD_W-1:0] op, int unsigned n, int unsigned rs);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= op;
    req_ch.block_count <= n[CNT_W-1:0];
    req_ch.range_start <= rs[BLK_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    pending_replies.push_back(apply_request(op, n, rs));
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DATA_START) shadow_ds = val & 10'h3FF;
    else shadow_total = val & 11'h7FF;
    @(posedge clk);
  endtask

  // Randomize receiver backpressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each reply with the oldest prediction
  always @(posedge clk) begin
    alloc_reply_t exp_r;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply with nothing expected");
        err_cnt++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, rsp_ch.status);
          err_cnt++;
        end
        if (rsp_ch.alloc_start !== exp_r.alloc_start) begin
          $error("alloc_start exp %0d got %0d", exp_r.alloc_start, rsp_ch.alloc_start);
          err_cnt++;
        end
        if (rsp_ch.free_left !== exp_r.free_left) begin
          $error("free_left exp %0d got %0d", exp_r.free_left, rsp_ch.free_left);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_ALLOC, 1, 1023);
    send_request(CMD_ALLOC, 1024, 0);
    send_request(CMD_ALLOC, 1023, 0);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_FREE, 2047, 1023);
    send_request(CMD_FREE, 1024, 0);
    send_request(CMD_ALLOC, 8, 0);
    send_request(CMD_FREE, 1, 0);
    send_request(CMD_FREE, 3, 5);
    send_request(CMD_ALLOC, 3, 0);
    send_request(CMD_SPARE, 2047, 1023);
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_ALLOC, 1000, 0);
    send_request(CMD_ALLOC, 30, 0);
    send_request(CMD_CLEAR, 1365, 682);
  endtask

  function automatic alloc_reply_t apply_peek();
    return pending_replies[$];
  endfunction

  // Mostly alloc/free of known runs with random sizes, some noise
  task automatic test_random(int items, int max_n);
    int unsigned runs_s [$];
    int unsigned runs_n [$];
    int unsigned pick, n, k;
    alloc_reply_t last_r;
    for (int it = 0; it < items; it++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(max_n);
        send_request(CMD_ALLOC, n, $urandom_range(1023));
        last_r = apply_peek();
        if (last_r.status == 1'b0) begin
          runs_s.push_back(last_r.alloc_start);
          runs_n.push_back(n);
        end
      end else if (pick < 85 && runs_s.size() != 0) begin
        k = $urandom_range(runs_s.size() - 1);
        send_request(CMD_FREE, runs_n[k], runs_s[k]);
        runs_s.delete(k);
        runs_n.delete(k);
      end else if (pick < 95) begin
        send_request(CMD_FREE, $urandom_range(2047), $urandom_range(1023));
      end else if (pick < 98) begin
        send_request(CMD_CLEAR, $urandom_range(2047), $urandom_range(1023));
        runs_s.delete();
        runs_n.delete();
      end else begin
        send_request(CMD_SPARE, $urandom_range(2047), $urandom_range(1023));
      end
    end
  endtask

  task automatic test_config_sweep();
    wait_drained();
    write_reg(CFG_DATA_START, 0);
    write_reg(CFG_BLOCK_TOTAL, 2047);
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_ALLOC, 1024, 0);
    send_request(CMD_FREE, 1024, 0);
    wait_drained();
    write_reg(CFG_DATA_START, 1023);
    write_reg(CFG_BLOCK_TOTAL, 1);
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_FREE, 5, 0);
    send_request(CMD_ALLOC, 1, 0);
    wait_drained();
    write_reg(CFG_DATA_START, 16);
    write_reg(CFG_BLOCK_TOTAL, 64);
    send_request(CMD_CLEAR, 0, 0);
    test_random(200, 12);
    wait_drained();
    write_reg(CFG_DATA_START, 5);
    write_reg(CFG_BLOCK_TOTAL, 1024);
    send_request(CMD_CLEAR, 0, 0);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ALLOC;
    req_ch.block_count = '0;
    req_ch.range_start = '0;
    rsp_ch.ready = 1'b0;
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    shadow_ds = DS_RST;
    shadow_total = BT_RST;
    shadow_free = CNT_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 75;
    test_directed();
    test_random(400, 40);
    wait_drained();
    send_request(CMD_ALLOC, 2, 0);
    send_idle_pct = 75;
    recv_idle_pct = 35;
    test_config_sweep();
    test_random(400, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400, 200);

    wait_drained();
    if (err_cnt == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
